### sv/hmpp_pkg.sv
package hmpp_pkg;

    // fixed geometry and number format
    localparam int SCREEN_W     = 1024;
    localparam int SCREEN_H     = 1024;
    localparam int FRAC_BITS    = 24;
    localparam int ESCAPE_LIMIT = 64;

    localparam int COORD_W  = 32;
    localparam int COLOR_W  = 16;
    localparam int PIXEL_W  = 10;
    localparam int OPND_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int REM_CNT_W = $clog2(COLOR_W + 1);

    // escape bound on |x| and |y|
    localparam logic [35:0] ESC_LIMIT = 36'(ESCAPE_LIMIT) << FRAC_BITS;

    // pixel = floor(d * scale / 2^PIX_SHIFT + 1/2)
    localparam int PIX_SHIFT = FRAC_BITS + 16;
    localparam logic [PROD_W-1:0] PIX_RND = PROD_W'(1) << (PIX_SHIFT - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_TOP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MOD = 3'd6;

    // multiplier operand selections
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_XX   = 3'd1;
    localparam logic [2:0] MUL_XC   = 3'd2;
    localparam logic [2:0] MUL_TS   = 3'd3;
    localparam logic [2:0] MUL_XS   = 3'd4;
    localparam logic [2:0] MUL_TC   = 3'd5;
    localparam logic [2:0] MUL_DX   = 3'd6;
    localparam logic [2:0] MUL_DY   = 3'd7;

    typedef struct packed {
        logic [31:0] cos_a;
        logic [31:0] sin_a;
        logic [31:0] x_origin;
        logic [31:0] y_top;
        logic [31:0] x_scale;
        logic [31:0] y_scale;
        logic [15:0] color_modulus;
    } cfg_t;

    typedef struct packed {
        logic       load_in;
        logic       check;
        logic [2:0] mul_op;
        logic       t_we;
        logic       acc_we;
        logic       xn_we;
        logic       pt_we;
        logic       px_we;
        logic       py_we;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic esc_hit;
        logic rem_done;
    } sts_t;

endpackage

### sv/hmpp_rem.sv
module hmpp_rem
    import hmpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COLOR_W-1:0] dividend,
    input  logic [COLOR_W-1:0] divisor,
    output logic               done,
    output logic [COLOR_W-1:0] remainder
);

    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic [COLOR_W-1:0]   q_reg, r_reg, m_reg;
    logic [COLOR_W:0]     trial;
    logic [COLOR_W-1:0]   r_step;

    // restoring remainder, one dividend bit a cycle
    // a zero divisor takes nothing away, so the dividend shifts through unreduced
    always_comb
    begin
        trial = {r_reg, q_reg[COLOR_W-1]};
        if (trial >= {1'b0, m_reg})
            r_step = COLOR_W'(trial - {1'b0, m_reg});
        else
            r_step = trial[COLOR_W-1:0];
        if (start)
            cnt_next = REM_CNT_W'(COLOR_W);
        else if (cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            m_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            q_reg <= {q_reg[COLOR_W-2:0], 1'b0};
            r_reg <= r_step;
        end
    end

    assign done      = (cnt_reg == '0);
    assign remainder = r_reg;

endmodule

### sv/hmpp_ctrl.sv
module hmpp_ctrl
    import hmpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_TSUB  = 4'd2;
    localparam logic [3:0] ST_XCOS  = 4'd3;
    localparam logic [3:0] ST_XNEW  = 4'd4;
    localparam logic [3:0] ST_XSIN  = 4'd5;
    localparam logic [3:0] ST_YNEW  = 4'd6;
    localparam logic [3:0] ST_DXMUL = 4'd7;
    localparam logic [3:0] ST_PXCHK = 4'd8;
    localparam logic [3:0] ST_PYCHK = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                cmd.mul_op = MUL_XX;
                state_next = sts.esc_hit ? ST_FIN : ST_TSUB;
            end
            ST_TSUB:
            begin
                cmd.t_we   = 1'b1;
                cmd.mul_op = MUL_XC;
                state_next = ST_XCOS;
            end
            ST_XCOS:
            begin
                cmd.acc_we = 1'b1;
                cmd.mul_op = MUL_TS;
                state_next = ST_XNEW;
            end
            ST_XNEW:
            begin
                cmd.xn_we  = 1'b1;
                cmd.mul_op = MUL_XS;
                state_next = ST_XSIN;
            end
            ST_XSIN:
            begin
                cmd.acc_we = 1'b1;
                cmd.mul_op = MUL_TC;
                state_next = ST_YNEW;
            end
            ST_YNEW:
            begin
                cmd.pt_we  = 1'b1;
                state_next = ST_DXMUL;
            end
            ST_DXMUL:
            begin
                cmd.mul_op = MUL_DX;
                state_next = ST_PXCHK;
            end
            ST_PXCHK:
            begin
                cmd.px_we  = 1'b1;
                cmd.mul_op = MUL_DY;
                state_next = ST_PYCHK;
            end
            ST_PYCHK:
            begin
                cmd.py_we  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.rem_done && out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### sv/hmpp_datapath.sv
module hmpp_datapath
    import hmpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    input  logic               restart,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COLOR_W-1:0] rem_value,
    output logic               esc_hit,
    output logic               plot_valid,
    output logic [PIXEL_W-1:0] pixel_x,
    output logic [PIXEL_W-1:0] pixel_y,
    output logic [COLOR_W-1:0] color,
    output logic               escaped
);

    localparam logic signed [SUM_W-1:0] T_HI   = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] T_LO   = -SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] S32_HI = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] S32_LO = -SUM_W'(64'sd2147483648);

    function automatic logic signed [COORD_W-1:0] sat32(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] lo,
        input logic signed [SUM_W-1:0] hi
    );
        logic signed [COORD_W-1:0] r;
        if (v < lo)
            r = lo[COORD_W-1:0];
        else if (v > hi)
            r = hi[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    logic signed [COORD_W-1:0] pt_x_reg, pt_y_reg;
    logic                      esc_flag_reg;
    logic signed [COORD_W-1:0] t_reg, xn_reg;
    logic signed [PROD_W-1:0]  prod_reg, acc_reg;
    logic                      res_esc_reg, x_ok_reg, y_ok_reg;
    logic [PIXEL_W-1:0]        px_reg, py_reg;

    logic                      plot_reg, escaped_reg;
    logic [PIXEL_W-1:0]        pixel_x_reg, pixel_y_reg;
    logic [COLOR_W-1:0]        color_reg;

    logic [OPND_W-1:0]         ax, ay;
    logic signed [OPND_W-1:0]  mul_a, mul_b, dx, dy;
    logic signed [SUM_W-1:0]   t_diff, x_sum, y_sum;
    logic signed [COORD_W-1:0] t_sat, xn_sat, yn_sat;
    logic [PROD_W-1:0]         pix;
    logic                      dx_pos, dy_pos, pix_pos;
    logic                      plot_now;

    // escape test on the stored point
    always_comb
    begin
        ax = pt_x_reg[COORD_W-1] ? OPND_W'(-$signed(OPND_W'(pt_x_reg))) : OPND_W'(pt_x_reg);
        ay = pt_y_reg[COORD_W-1] ? OPND_W'(-$signed(OPND_W'(pt_y_reg))) : OPND_W'(pt_y_reg);
        esc_hit = esc_flag_reg || ({3'b000, ax} >= ESC_LIMIT) || ({3'b000, ay} >= ESC_LIMIT);
    end

    // distances from the screen edges
    assign dx     = OPND_W'(pt_x_reg) - OPND_W'($signed(cfg.x_origin));
    assign dy     = OPND_W'($signed(cfg.y_top)) - OPND_W'(pt_y_reg);
    assign dx_pos = !dx[OPND_W-1] && (dx != '0);
    assign dy_pos = !dy[OPND_W-1] && (dy != '0);

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            MUL_XX:
            begin
                mul_a = OPND_W'(pt_x_reg);
                mul_b = OPND_W'(pt_x_reg);
            end
            MUL_XC:
            begin
                mul_a = OPND_W'(pt_x_reg);
                mul_b = OPND_W'($signed(cfg.cos_a));
            end
            MUL_TS:
            begin
                mul_a = OPND_W'(t_reg);
                mul_b = OPND_W'($signed(cfg.sin_a));
            end
            MUL_XS:
            begin
                mul_a = OPND_W'(pt_x_reg);
                mul_b = OPND_W'($signed(cfg.sin_a));
            end
            MUL_TC:
            begin
                mul_a = OPND_W'(t_reg);
                mul_b = OPND_W'($signed(cfg.cos_a));
            end
            MUL_DX:
            begin
                mul_a = dx;
                mul_b = $signed({1'b0, cfg.x_scale});
            end
            MUL_DY:
            begin
                mul_a = dy;
                mul_b = $signed({1'b0, cfg.y_scale});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // t = y - floor(x*x), rotated point, pixel rounding
    always_comb
    begin
        t_diff  = SUM_W'(pt_y_reg) - SUM_W'(prod_reg >>> FRAC_BITS);
        t_sat   = sat32(t_diff, T_LO, T_HI);
        x_sum   = (SUM_W'(acc_reg) - SUM_W'(prod_reg)) >>> FRAC_BITS;
        y_sum   = (SUM_W'(acc_reg) + SUM_W'(prod_reg)) >>> FRAC_BITS;
        xn_sat  = sat32(x_sum, S32_LO, S32_HI);
        yn_sat  = sat32(y_sum, S32_LO, S32_HI);
        pix     = ($unsigned(prod_reg) + PIX_RND) >> PIX_SHIFT;
        pix_pos = (pix != '0);
    end

    assign plot_now = !res_esc_reg && x_ok_reg && y_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_x_reg     <= '0;
            pt_y_reg     <= '0;
            esc_flag_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in && restart)
            begin
                pt_x_reg     <= $signed(start_x);
                pt_y_reg     <= $signed(start_y);
                esc_flag_reg <= 1'b0;
            end
            else if (cmd.check && esc_hit)
            begin
                esc_flag_reg <= 1'b1;
            end
            else if (cmd.pt_we)
            begin
                pt_x_reg <= xn_reg;
                pt_y_reg <= yn_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.check)
            res_esc_reg <= esc_hit;
        if (cmd.t_we)
            t_reg <= t_sat;
        if (cmd.acc_we)
            acc_reg <= prod_reg;
        if (cmd.xn_we)
            xn_reg <= xn_sat;
        if (cmd.px_we)
        begin
            x_ok_reg <= dx_pos && pix_pos && (pix < PROD_W'(SCREEN_W));
            px_reg   <= pix[PIXEL_W-1:0];
        end
        if (cmd.py_we)
        begin
            y_ok_reg <= dy_pos && pix_pos && (pix < PROD_W'(SCREEN_H));
            py_reg   <= pix[PIXEL_W-1:0];
        end
        if (cmd.load_out)
        begin
            plot_reg    <= plot_now;
            escaped_reg <= res_esc_reg;
            pixel_x_reg <= plot_now ? px_reg : '0;
            pixel_y_reg <= plot_now ? py_reg : '0;
            color_reg   <= plot_now ? rem_value : '0;
        end
    end

    assign plot_valid = plot_reg;
    assign escaped    = escaped_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign color      = color_reg;

endmodule

### sv/henon_map_point_plotter.sv
// channel   | direction | tdata (low bit up)                          | tuser
// ----------+-----------+---------------------------------------------+---------------------
// s_*       | in        | start_x 32, start_y 32, orbit_index 16      | restart
// m_*       | out       | pixel_x 10, pixel_y 10, color 16, pad 4     | plot_valid, escaped
// cfg_*     | in        | write enable, 3-bit register index, 32-bit data
//
// one request at a time; between accepts, while the output is free, the block runs
// nine sequencer steps, seven of them products on the shared 33x33 multiplier, with the
// colour remainder running alongside and setting the length; a frozen point still waits
// for the remainder
// a finished result sits in the output register while the next request is taken
// the output stalls the block only when a new result is ready and the old one is unread
// rst_n clears the point, the escape flag, the control state and the configuration registers to defaults
module henon_map_point_plotter
    import hmpp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input requests
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [79:0]          s_tdata,   // start_x, start_y, orbit_index
    input  logic                 s_tuser,   // restart
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // pixel_x, pixel_y, color, zero pad
    output logic [1:0]           m_tuser,   // plot_valid, escaped
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    logic               esc_hit;
    logic               rem_done;
    logic [COLOR_W-1:0] rem_value;

    logic               plot_valid;
    logic               escaped;
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color;

    // register file, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_a         <= 32'h0100_0000;
            cfg_reg.sin_a         <= '0;
            cfg_reg.x_origin      <= '0;
            cfg_reg.y_top         <= '0;
            cfg_reg.x_scale       <= 32'h0001_0000;
            cfg_reg.y_scale       <= 32'h0001_0000;
            cfg_reg.color_modulus <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COS_A:     cfg_reg.cos_a         <= cfg_data;
                REG_SIN_A:     cfg_reg.sin_a         <= cfg_data;
                REG_X_ORIGIN:  cfg_reg.x_origin      <= cfg_data;
                REG_Y_TOP:     cfg_reg.y_top         <= cfg_data;
                REG_X_SCALE:   cfg_reg.x_scale       <= cfg_data;
                REG_Y_SCALE:   cfg_reg.y_scale       <= cfg_data;
                REG_COLOR_MOD: cfg_reg.color_modulus <= cfg_data[COLOR_W-1:0];
                default:       ;
            endcase
        end
    end

    assign sts.esc_hit  = esc_hit;
    assign sts.rem_done = rem_done;

    // sequencer for the multiply chain and the output register
    hmpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // point state, shared multiplier, pixel mapping
    hmpp_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .restart    (s_tuser),
        .start_x    (s_tdata[31:0]),
        .start_y    (s_tdata[63:32]),
        .rem_value  (rem_value),
        .esc_hit    (esc_hit),
        .plot_valid (plot_valid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .color      (color),
        .escaped    (escaped)
    );

    // colour = orbit_index mod color_modulus (orbit_index for a zero modulus), started at accept
    hmpp_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.load_in),
        .dividend  (s_tdata[79:64]),
        .divisor   (cfg_reg.color_modulus),
        .done      (rem_done),
        .remainder (rem_value)
    );

    assign m_tdata = {4'b0000, color, pixel_y, pixel_x};
    assign m_tuser = {escaped, plot_valid};

endmodule

### tb/testbench.sv
module testbench;
    import hmpp_pkg::*;

    localparam int CLK_PERIOD = 12;

    // handy Q8.24 values for the directed requests
    localparam logic [31:0] Q_ONE   = 32'(1) << FRAC_BITS;
    localparam logic [31:0] Q_HALF  = Q_ONE >> 1;
    localparam logic [31:0] Q_LIMIT = 32'(ESCAPE_LIMIT) << FRAC_BITS;

    // one input request as it travels on s_tdata / s_tuser
    typedef struct packed {
        logic        restart;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [15:0] orbit_index;
    } orbit_req_t;

    // one result as it travels on m_tdata / m_tuser
    typedef struct packed {
        logic               plot_valid;
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
        logic [COLOR_W-1:0] color;
        logic               escaped;
    } plot_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [79:0]          s_tdata = '0;    // start_x, start_y, orbit_index
    logic                 s_tuser = 1'b0;  // restart
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;         // pixel_x, pixel_y, color, zero pad
    logic [1:0]           m_tuser;         // plot_valid, escaped
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // shadow of the configuration registers, reset values
    logic signed [31:0] cos_q   = 32'sh0100_0000;
    logic signed [31:0] sin_q   = '0;
    logic signed [31:0] x_org_q = '0;
    logic signed [31:0] y_top_q = '0;
    logic [31:0]        x_scl_q = 32'h0001_0000;
    logic [31:0]        y_scl_q = 32'h0001_0000;
    logic [15:0]        col_mod_q = 16'd256;

    // shadow of the orbit state
    logic signed [31:0] orbit_x = '0;
    logic signed [31:0] orbit_y = '0;
    logic               orbit_frozen = 1'b0;

    orbit_req_t orbit_reqs[$];      // requests waiting to be offered
    plot_t      expected_plots[$];  // predictions for accepted requests
    orbit_req_t bus_req;            // request currently on the input bus
    int         items_queued = 0;
    int         results_seen = 0;
    int         plot_errors = 0;
    int         send_gap_pct = 0;
    int         recv_stall_pct = 0;

    henon_map_point_plotter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // one map iteration on the shadow orbit, giving the expected result
    function automatic plot_t henon_step(orbit_req_t req);
        logic signed [71:0] x, y, ax, ay, sq, t, xn, yn, dx, dy;
        logic signed [71:0] c, s, xo, yt, bound, hi, lo;
        logic [79:0]        px, py;
        plot_t              res;
        res   = '0;
        bound = 72'(ESCAPE_LIMIT) <<< FRAC_BITS;
        hi    = 72'sd2147483647;
        lo    = -72'sd2147483648;
        if (req.restart)
        begin
            orbit_x      = req.start_x;
            orbit_y      = req.start_y;
            orbit_frozen = 1'b0;
        end
        x  = orbit_x;
        y  = orbit_y;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        // a point at or past the escape bound freezes until the next restart
        if (orbit_frozen || ax >= bound || ay >= bound)
        begin
            orbit_frozen = 1'b1;
            res.escaped  = 1'b1;
            return res;
        end
        c  = cos_q;
        s  = sin_q;
        xo = x_org_q;
        yt = y_top_q;
        // t = y - x^2, held to +-(2^31 - 1)
        sq = (x * x) >>> FRAC_BITS;
        t  = y - sq;
        if (t > hi)
            t = hi;
        else if (t < -hi)
            t = -hi;
        // rotation, floored, then held to the 32-bit range
        xn = (x * c - t * s) >>> FRAC_BITS;
        yn = (x * s + t * c) >>> FRAC_BITS;
        if (xn > hi)
            xn = hi;
        else if (xn < lo)
            xn = lo;
        if (yn > hi)
            yn = hi;
        else if (yn < lo)
            yn = lo;
        orbit_x = xn[31:0];
        orbit_y = yn[31:0];
        // screen mapping, round to nearest, strictly inside the screen
        dx = xn - xo;
        dy = yt - yn;
        if (dx > 0 && dy > 0)
        begin
            px = (80'(dx) * 80'(x_scl_q) + (80'd1 << (FRAC_BITS + 15))) >> (FRAC_BITS + 16);
            py = (80'(dy) * 80'(y_scl_q) + (80'd1 << (FRAC_BITS + 15))) >> (FRAC_BITS + 16);
            if (px > 0 && px < SCREEN_W && py > 0 && py < SCREEN_H)
            begin
                res.plot_valid = 1'b1;
                res.pixel_x    = px[PIXEL_W-1:0];
                res.pixel_y    = py[PIXEL_W-1:0];
                // a zero modulus passes the orbit index through
                res.color      = (col_mod_q == 0) ? req.orbit_index
                                                  : req.orbit_index % col_mod_q;
            end
        end
        return res;
    endfunction

    // request driver: holds a request until taken, random gaps between requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_plots.push_back(henon_step(bus_req));
            if (!s_tvalid || s_tready)
            begin
                if (orbit_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    bus_req = orbit_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {bus_req.orbit_index, bus_req.start_y, bus_req.start_x};
                    s_tuser  <= bus_req.restart;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor: random back-pressure, compare against the oldest prediction
    always @(posedge clk)
    begin : result_check
        plot_t seen;
        plot_t want;
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            seen.plot_valid = m_tuser[0];
            seen.escaped    = m_tuser[1];
            seen.pixel_x    = m_tdata[9:0];
            seen.pixel_y    = m_tdata[19:10];
            seen.color      = m_tdata[35:20];
            if (expected_plots.size() == 0)
            begin
                plot_errors++;
                if (plot_errors <= 10)
                    $display("result with nothing expected: valid=%0d x=%0d y=%0d",
                             seen.plot_valid, seen.pixel_x, seen.pixel_y,
                             " color=%0d esc=%0d", seen.color, seen.escaped);
            end
            else
            begin
                want = expected_plots.pop_front();
                if (seen !== want)
                begin
                    plot_errors++;
                    if (plot_errors <= 10)
                    begin
                        $display("plot mismatch: expected valid=%0d x=%0d y=%0d",
                                 want.plot_valid, want.pixel_x, want.pixel_y,
                                 " color=%0d esc=%0d", want.color, want.escaped);
                        $display("               got      valid=%0d x=%0d y=%0d",
                                 seen.plot_valid, seen.pixel_x, seen.pixel_y,
                                 " color=%0d esc=%0d", seen.color, seen.escaped);
                    end
                end
            end
        end
    end

    task automatic push_req(logic restart, logic [31:0] sx, logic [31:0] sy, logic [15:0] idx);
        orbit_reqs.push_back('{restart, sx, sy, idx});
        items_queued++;
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_COS_A:     cos_q     = val;
            REG_SIN_A:     sin_q     = val;
            REG_X_ORIGIN:  x_org_q   = val;
            REG_Y_TOP:     y_top_q   = val;
            REG_X_SCALE:   x_scl_q   = val;
            REG_Y_SCALE:   y_scl_q   = val;
            REG_COLOR_MOD: col_mod_q = val[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender stays quiet until a result is back for every queued request
    task automatic wait_drained();
        while (results_seen < items_queued)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // random rotation with a window of about +-2 world units on screen
    task automatic set_view(logic [15:0] modulus);
        real angle;
        angle = $urandom_range(0, 62831) / 10000.0;
        write_reg(REG_COS_A, $rtoi($cos(angle) * 16777216.0));
        write_reg(REG_SIN_A, $rtoi($sin(angle) * 16777216.0));
        write_reg(REG_X_ORIGIN, 32'd0 - 32'($urandom_range(25165824, 41943040)));
        write_reg(REG_Y_TOP, 32'($urandom_range(25165824, 41943040)));
        write_reg(REG_X_SCALE, {16'($urandom_range(140, 600)), 16'($urandom)});
        write_reg(REG_Y_SCALE, {16'($urandom_range(140, 600)), 16'($urandom)});
        write_reg(REG_COLOR_MOD, 32'(modulus));
    endtask

    // restart inside +-1.5, then a run of plain steps with junk start fields
    task automatic add_orbit(int steps);
        logic [15:0] orbit_no;
        orbit_no = 16'($urandom);
        push_req(1'b1, 32'($urandom_range(0, 50331648)) - 32'd25165824,
                 32'($urandom_range(0, 50331648)) - 32'd25165824, orbit_no);
        for (int i = 0; i < steps; i++)
            push_req(1'b0, $urandom, $urandom, orbit_no);
    endtask

    // mostly well-formed orbits, some fully random requests
    task automatic add_random(int count);
        int target;
        target = items_queued + count;
        while (items_queued < target)
        begin
            if ($urandom_range(0, 9) < 8)
                add_orbit($urandom_range(4, 40));
            else
                push_req(1'($urandom_range(0, 1)), $urandom, $urandom, 16'($urandom));
        end
    endtask

    initial
    begin
        send_gap_pct   = 21;
        recv_stall_pct = 87;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: identity rotation, unit scale
        push_req(1'b0, 32'h0, 32'h0, 16'h0000);               // step from the reset point
        push_req(1'b1, Q_ONE, 32'h0, 16'hFFFF);               // lands on pixel (1,1)
        push_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0100);
        push_req(1'b1, Q_HALF, 32'h0 - (Q_ONE + (Q_ONE >> 2)), 16'h00FF); // half rounds up
        push_req(1'b1, Q_HALF - 1, 32'h0 - (Q_ONE + (Q_ONE >> 2)), 16'h00FF);
        push_req(1'b1, 32'h7FFF_FFFF, 32'h0, 16'h8000);       // escapes at once
        push_req(1'b0, 32'h0, 32'h0, 16'h0001);               // stays frozen
        push_req(1'b1, 32'h0, 32'h8000_0000, 16'h7FFF);
        push_req(1'b1, Q_LIMIT, 32'h0, 16'h0002);             // magnitude exactly at the bound
        push_req(1'b1, 32'h0 - Q_LIMIT, 32'h0, 16'h0003);
        push_req(1'b1, 32'h0, 32'h0 - Q_LIMIT, 16'h0004);
        push_req(1'b1, Q_LIMIT - 1, Q_LIMIT - 1, 16'h0005);   // t saturates
        push_req(1'b0, 32'h0, 32'h0, 16'h0006);               // then escapes
        push_req(1'b1, 32'h0 - (Q_LIMIT - 1), 32'h0 - (Q_LIMIT - 1), 16'h0007);
        push_req(1'b1, 32'h0, 32'h0, 16'h0008);               // restart replaces a point past the bound
        wait_drained();

        set_view(16'($urandom_range(2, 300)));
        add_random(450);
        wait_drained();

        // extreme registers, one way round
        write_reg(REG_COS_A, 32'h7FFF_FFFF);
        write_reg(REG_SIN_A, 32'h8000_0000);
        write_reg(REG_X_ORIGIN, 32'h8000_0000);
        write_reg(REG_Y_TOP, 32'h7FFF_FFFF);
        write_reg(REG_X_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_Y_SCALE, 32'h0);
        write_reg(REG_COLOR_MOD, 32'd1);
        push_req(1'b1, Q_ONE, Q_HALF, 16'hFFFF);
        push_req(1'b0, 32'h0, 32'h0, 16'hFFFF);
        push_req(1'b1, 32'h0 - (Q_LIMIT - 1), Q_LIMIT - 1, 16'h0000); // products saturate
        add_random(120);
        wait_drained();

        // swap idling, extreme registers the other way round
        send_gap_pct   = 87;
        recv_stall_pct = 21;
        write_reg(REG_COS_A, 32'h8000_0000);
        write_reg(REG_SIN_A, 32'h7FFF_FFFF);
        write_reg(REG_X_ORIGIN, 32'h7FFF_FFFF);
        write_reg(REG_Y_TOP, 32'h8000_0000);
        write_reg(REG_X_SCALE, 32'h0);
        write_reg(REG_Y_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_COLOR_MOD, 32'hFFFF);
        push_req(1'b1, Q_HALF, 32'h0 - Q_ONE, 16'h1234);
        push_req(1'b0, 32'h0, 32'h0, 16'h1234);
        add_random(120);
        wait_drained();

        set_view(16'hFFFF);
        add_random(450);
        wait_drained();

        // no idling on either side
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_view(16'h0);
        add_random(150);
        wait_drained();

        set_view(16'h1);
        add_random(150);
        wait_drained();

        set_view(16'($urandom_range(1, 65535)));
        add_random(250);
        wait_drained();

        repeat (40) @(posedge clk);
        if (plot_errors == 0 && expected_plots.size() == 0)
            $display("henon_map_point_plotter test passed");
        else
            $display("henon_map_point_plotter test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(CLK_PERIOD * 800000);
        $display("henon_map_point_plotter test failed");
        $finish;
    end

endmodule
